@@ design/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants and helpers for the tridiagonal system solver.
// ----------------------------------------------------------------------------
`default_nettype none
package tss_pkg;

  localparam int unsigned MaxRowsDef  = 32;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned RowW        = 6;

  localparam logic signed [DataW-1:0] QMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] QMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_RATIO,
    ST_MUL_RHS,
    ST_DIV_RHS,
    ST_WAIT_RHS,
    ST_DIV_RATIO,
    ST_WAIT_RATIO,
    ST_EMIT_FIRST,
    ST_BACK_MUL,
    ST_BACK_EMIT
  } tss_state_e;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic logic [DataW:0] sat_diff(input logic signed [DataW:0] v);
    logic [DataW:0] r;
    if (v > $signed({1'b0, QMax})) r = {1'b1, QMax};
    else if (v < $signed({1'b1, QMin})) r = {1'b1, QMin};
    else r = {1'b0, v[DataW-1:0]};
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/tss_divider.sv @@
// ----------------------------------------------------------------------------
// tss_divider
// Radix-2 restoring divider: (n << FRAC_BITS) / d, truncated, saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module tss_divider
  import tss_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire  signed [DataW-1:0] num_i,
  input  wire  signed [DataW-1:0] den_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] quot_o,
  output logic                    err_o
);

  localparam int unsigned NW  = DataW + FRAC_BITS;
  localparam int unsigned CW  = $clog2(NW + 1);

  logic [NW-1:0]    num_q, num_d;
  logic [DataW-1:0] den_q, den_d;
  logic [DataW:0]   rem_q, rem_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             neg_q, neg_d, zero_q, zero_d, run_q, run_d, done_d, done_q;
  logic [DataW:0]   trial;
  logic [NW-1:0]    mag;
  logic [NW:0]      sq;

  always_comb begin
    num_d = num_q; den_d = den_q; rem_d = rem_q; cnt_d = cnt_q;
    neg_d = neg_q; zero_d = zero_q; run_d = run_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      num_d  = NW'({num_i[DataW-1] ? -{{FRAC_BITS{num_i[DataW-1]}}, num_i} :
                     {{FRAC_BITS{1'b0}}, num_i}} << FRAC_BITS);
      den_d  = den_i[DataW-1] ? -den_i : den_i;
      rem_d  = '0;
      cnt_d  = CW'(NW);
      neg_d  = num_i[DataW-1] ^ den_i[DataW-1];
      zero_d = (den_i == '0);
      run_d  = 1'b1;
    end else if (run_q) begin
      trial = {rem_q[DataW-1:0], num_q[NW-1]};
      num_d = {num_q[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d;
    neg_q <= neg_d; zero_q <= zero_d;
  end

  always_comb begin
    mag = num_q;
    sq  = neg_q ? -{1'b0, mag} : {1'b0, mag};
    err_o = 1'b0;
    if (zero_q) begin
      err_o  = 1'b1;
      quot_o = neg_q ? QMin : QMax;
    end else if ($signed(sq) > $signed((NW+1)'(QMax))) begin
      err_o = 1'b1; quot_o = QMax;
    end else if ($signed(sq) < $signed({{(NW+1-DataW){1'b1}}, QMin})) begin
      err_o = 1'b1; quot_o = QMin;
    end else begin
      quot_o = sq[DataW-1:0];
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

@@ design/tss_mul.sv @@
// ----------------------------------------------------------------------------
// tss_mul
// Registered fixed-point product, floor shift, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module tss_mul
  import tss_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire                     clk_i,
  input  wire  signed [DataW-1:0] a_i,
  input  wire  signed [DataW-1:0] b_i,
  output logic signed [DataW-1:0] prod_o,
  output logic                    err_o
);

  logic signed [2*DataW-1:0] p_q;
  logic signed [2*DataW-1:0] sh;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  always_comb begin
    sh = p_q >>> FRAC_BITS;
    err_o = 1'b0;
    if (sh > $signed({{DataW{1'b0}}, QMax})) begin
      err_o = 1'b1; prod_o = QMax;
    end else if (sh < $signed({{DataW{1'b1}}, QMin})) begin
      err_o = 1'b1; prod_o = QMin;
    end else begin
      prod_o = sh[DataW-1:0];
    end
  end

endmodule
`default_nettype wire

@@ design/tridiagonal_system_solver_unit.sv @@
// ----------------------------------------------------------------------------
// tridiagonal_system_solver_unit
// Thomas-algorithm solver for signed fixed-point tridiagonal systems.
// ----------------------------------------------------------------------------
// Usage: drive one matrix row on the *_i ports with start high while busy
// is low. Rows run the forward sweep on one shared iterative divider: each
// row takes two divisions, one for its right-hand side and one for its
// ratio, after its multiply states; busy stays high while a row is in the
// sweep, so a new row is taken only when the last one is through.
// The final row (last_row_i or MAX_ROWS rows) needs one division, and its
// solution is the first one emitted.
// Back substitution then emits one solution per row, last row first, each on
// result_valid_o for one cycle; each result after the first takes one
// registered multiply; run_end_o marks row zero, and busy drops after
// it. The receiver cannot stall; results are not held.
// Reset clears the sequencer, row counter, last-row flag and error flag; the
// row stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module tridiagonal_system_solver_unit
  import tss_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = MaxRowsDef,
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start,
  output logic                    busy,
  input  wire  signed [DataW-1:0] sub_coef_i,
  input  wire  signed [DataW-1:0] diag_coef_i,
  input  wire  signed [DataW-1:0] super_coef_i,
  input  wire  signed [DataW-1:0] rhs_value_i,
  input  wire                     last_row_i,
  output logic                    result_valid_o,
  output logic [RowW-1:0]         row_index_o,
  output logic signed [DataW-1:0] solution_o,
  output logic                    run_end_o,
  output logic                    singular_o
);

  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic signed [DataW-1:0] ratio_mem [MAX_ROWS];
  logic signed [DataW-1:0] prhs_mem  [MAX_ROWS];

  tss_state_e state_q, state_d;
  logic [RowW-1:0] row_q, row_d;
  logic            err_q, err_d;
  logic            last_q, last_d;
  logic signed [DataW-1:0] sub_q, diag_q, sup_q, rhs_q, piv_q, piv_d;
  logic signed [DataW-1:0] x_q, x_d, rat_rd_q, prhs_rd_q;
  logic signed [DataW-1:0] mul_a, mul_b, prod, div_n, div_d, quot;
  logic            mul_err, div_err;
  logic            div_start, div_done;
  logic            wr_ratio, wr_prhs;
  logic [AW-1:0]   row_a, rd_a;
  logic [DataW:0]  dres;
  logic            accept;

  assign accept = start && !busy;
  assign row_a  = row_q[AW-1:0];

  tss_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .prod_o(prod), .err_o(mul_err)
  );

  tss_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_n),
    .den_i(div_d), .done_o(div_done), .quot_o(quot), .err_o(div_err)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sub_q <= sub_coef_i; diag_q <= diag_coef_i;
      sup_q <= super_coef_i; rhs_q <= rhs_value_i;
    end
    piv_q <= piv_d;
    x_q   <= x_d;
    if (wr_ratio) ratio_mem[row_a] <= quot;
    if (wr_prhs)  prhs_mem[row_a]  <= quot;
    rat_rd_q  <= ratio_mem[rd_a];
    prhs_rd_q <= prhs_mem[rd_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; row_q <= '0; err_q <= 1'b0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; row_q <= row_d; err_q <= err_d; last_q <= last_d;
    end
  end

  always_comb begin
    state_d = state_q; row_d = row_q; err_d = err_q; last_d = last_q;
    piv_d = piv_q; x_d = x_q;
    div_start = 1'b0;
    wr_ratio = 1'b0; wr_prhs = 1'b0;
    mul_a = sub_q; mul_b = rat_rd_q;
    div_n = rhs_q; div_d = piv_q;
    rd_a = (row_q == '0) ? '0 : AW'(row_q - 1'b1);
    dres = '0;
    result_valid_o = 1'b0;
    busy = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = last_row_i || (row_q == RowW'(MAX_ROWS - 1));
          if (row_q == '0) err_d = 1'b0;
          state_d = ST_MUL_RATIO;
        end
      end
      ST_MUL_RATIO: begin
        // ratio of previous row was read last cycle; product registers now
        mul_b = rat_rd_q;
        state_d = ST_MUL_RHS;
      end
      ST_MUL_RHS: begin
        mul_b = prhs_rd_q;
        if (row_q == '0) begin
          piv_d = diag_q;
        end else begin
          dres  = sat_diff($signed({diag_q[DataW-1], diag_q}) -
                           $signed({prod[DataW-1], prod}));
          piv_d = dres[DataW-1:0];
          if (dres[DataW] || mul_err) err_d = 1'b1;
        end
        state_d = ST_DIV_RHS;
      end
      ST_DIV_RHS: begin
        if (row_q == '0) begin
          div_n = rhs_q;
        end else begin
          dres  = sat_diff($signed({rhs_q[DataW-1], rhs_q}) -
                           $signed({prod[DataW-1], prod}));
          div_n = dres[DataW-1:0];
          if (dres[DataW] || mul_err) err_d = 1'b1;
        end
        div_start = 1'b1;
        state_d = ST_WAIT_RHS;
      end
      ST_WAIT_RHS: begin
        if (div_done) begin
          wr_prhs = 1'b1;
          x_d = quot;
          if (div_err) err_d = 1'b1;
          if (last_q) begin
            state_d = ST_EMIT_FIRST;
          end else state_d = ST_DIV_RATIO;
        end
      end
      ST_DIV_RATIO: begin
        div_n = sup_q;
        div_start = 1'b1;
        state_d = ST_WAIT_RATIO;
      end
      ST_WAIT_RATIO: begin
        div_n = sup_q;
        if (div_done) begin
          wr_ratio = 1'b1;
          if (div_err) err_d = 1'b1;
          row_d = row_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_FIRST: begin
        result_valid_o = 1'b1;
        rd_a = row_a - 1'b1;
        if (row_q == '0) begin
          row_d = '0; state_d = ST_IDLE;
        end else begin
          row_d = row_q - 1'b1; state_d = ST_BACK_MUL;
        end
      end
      ST_BACK_MUL: begin
        rd_a  = row_a;
        mul_a = rat_rd_q; mul_b = x_q;
        state_d = ST_BACK_EMIT;
      end
      ST_BACK_EMIT: begin
        rd_a = row_a - 1'b1;
        dres = sat_diff($signed({prhs_rd_q[DataW-1], prhs_rd_q}) -
                        $signed({prod[DataW-1], prod}));
        x_d = dres[DataW-1:0];
        if (dres[DataW] || mul_err) err_d = 1'b1;
        result_valid_o = 1'b1;
        if (row_q == '0) state_d = ST_IDLE;
        else begin
          row_d = row_q - 1'b1; state_d = ST_BACK_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    row_index_o = row_q;
    run_end_o   = (row_q == '0);
    solution_o  = x_q;
    singular_o  = err_q;
    if (state_q == ST_BACK_EMIT) begin
      solution_o = dres[DataW-1:0];
      singular_o = err_q || dres[DataW] || mul_err;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result outside busy window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && run_end_o) |=> (state_q == ST_IDLE && row_q == '0))
    else $error("run did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !result_valid_o)
    else $error("result while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == ST_WAIT_RHS || state_q == ST_WAIT_RATIO))
    else $error("divider started without wait");

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the tridiagonal system solver: rows go in as start requests, each
// system's solutions are predicted in fixed point and compared entry by entry.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import tss_pkg::*;

  localparam int unsigned NRows = MaxRowsDef;
  localparam int unsigned FracB = FracBitsDef;
  localparam int NDirected = 20;

  typedef struct {
    logic signed [31:0] sub_c;
    logic signed [31:0] diag_c;
    logic signed [31:0] sup_c;
    logic signed [31:0] rhs_c;
    logic               last_c;
    logic               chk;
    logic signed [31:0] exp_x;
    logic               exp_sing;
  } row_req_t;

  typedef struct {
    logic [RowW-1:0]    idx;
    logic signed [31:0] x;
    logic               run_end;
    logic               sing;
  } solution_t;

  logic clk_i, rst_ni, start, last_row_i;
  logic busy, result_valid_o, run_end_o, singular_o;
  logic signed [31:0] sub_coef_i, diag_coef_i, super_coef_i, rhs_value_i;
  logic [RowW-1:0] row_index_o;
  logic signed [31:0] solution_o;

  tridiagonal_system_solver_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .sub_coef_i, .diag_coef_i, .super_coef_i,
    .rhs_value_i, .last_row_i, .result_valid_o, .row_index_o, .solution_o,
    .run_end_o, .singular_o
  );

  always begin
    clk_i = 1'b0; #4;
    clk_i = 1'b1; #4;
  end

  logic signed [63:0] ratio_mem [NRows];
  logic signed [63:0] prhs_mem [NRows];
  int unsigned rows_taken;
  bit err_flag;
  solution_t pending_solutions[$];
  int unsigned n_fail, n_rows, n_solutions, n_systems;

  function automatic logic signed [63:0] fx_sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      err_flag = 1'b1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      err_flag = 1'b1; return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    return fx_sat((a * b) >>> FracB);
  endfunction

  function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                input logic signed [63:0] d);
    if (d == 0) begin
      err_flag = 1'b1;
      return (n >= 0) ? 64'sd2147483647 : -64'sd2147483648;
    end
    return fx_sat((n <<< FracB) / d);
  endfunction

  task automatic solve_row(input row_req_t r);
    int unsigned i;
    logic signed [63:0] piv, pr, xs;
    bit fin;
    solution_t s;
    i = rows_taken;
    fin = r.last_c;
    if (i >= NRows) i = 0;
    if (i == 0) begin
      err_flag = 1'b0;
      piv = r.diag_c;
      pr = fx_div(r.rhs_c, piv);
    end else begin
      piv = fx_sat(r.diag_c - fx_mul(r.sub_c, ratio_mem[i-1]));
      pr = fx_div(fx_sat(r.rhs_c - fx_mul(r.sub_c, prhs_mem[i-1])), piv);
    end
    prhs_mem[i] = pr;
    if (i + 1 >= NRows) fin = 1'b1;
    if (!fin) begin
      ratio_mem[i] = fx_div(r.sup_c, piv);
      rows_taken = i + 1;
      return;
    end
    xs = prhs_mem[i];
    for (int k = 0; k <= int'(i); k++) begin
      int unsigned row;
      row = i - k;
      if (k > 0) xs = fx_sat(prhs_mem[row] - fx_mul(ratio_mem[row], xs));
      s.idx = row[RowW-1:0];
      s.x = xs[31:0];
      s.run_end = (row == 0);
      s.sing = err_flag;
      pending_solutions.push_back(s);
    end
    if (r.chk) begin
      if (pending_solutions[$].x !== r.exp_x) begin
        $error("table solution exp %0d got %0d", r.exp_x, pending_solutions[$].x);
        n_fail++;
      end
      if (pending_solutions[$].sing !== r.exp_sing) begin
        $error("table singular exp %0b got %0b", r.exp_sing, pending_solutions[$].sing);
        n_fail++;
      end
    end
    rows_taken = 0;
    err_flag = 1'b0;
    n_systems++;
  endtask

  always @(posedge clk_i) begin
    solution_t e;
    if (rst_ni && result_valid_o) begin
      n_solutions++;
      if (pending_solutions.size() == 0) begin
        $error("unexpected solution row %0d", row_index_o);
        n_fail++;
      end else begin
        e = pending_solutions.pop_front();
        if (row_index_o !== e.idx) begin
          $error("row_index exp %0d got %0d", e.idx, row_index_o); n_fail++;
        end
        if (solution_o !== e.x) begin
          $error("solution exp %0d got %0d", e.x, solution_o); n_fail++;
        end
        if (run_end_o !== e.run_end) begin
          $error("run_end exp %0b got %0b", e.run_end, run_end_o); n_fail++;
        end
        if (singular_o !== e.sing) begin
          $error("singular exp %0b got %0b", e.sing, singular_o); n_fail++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic row_req_t mk_row(input logic signed [31:0] s, input logic signed [31:0] d,
                                      input logic signed [31:0] u, input logic signed [31:0] b,
                                      input logic l);
    row_req_t r;
    r.sub_c = s; r.diag_c = d; r.sup_c = u; r.rhs_c = b; r.last_c = l;
    r.chk = 1'b0; r.exp_x = '0; r.exp_sing = 1'b0;
    return r;
  endfunction

  function automatic row_req_t mk_chk(input row_req_t r, input logic signed [31:0] x,
                                      input logic sg);
    r.chk = 1'b1; r.exp_x = x; r.exp_sing = sg;
    return r;
  endfunction

  // start stays high across a zero gap; drop it only when a gap follows
  task automatic send_row(input row_req_t r);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    sub_coef_i <= r.sub_c; diag_coef_i <= r.diag_c;
    super_coef_i <= r.sup_c; rhs_value_i <= r.rhs_c; last_row_i <= r.last_c;
    do @(posedge clk_i); while (busy);
    solve_row(r);
    n_rows++;
  endtask

  row_req_t dir_rows[NDirected];

  initial begin
    int len;
    start = 1'b0; last_row_i = 1'b0;
    sub_coef_i = '0; diag_coef_i = '0; super_coef_i = '0; rhs_value_i = '0;
    rows_taken = 0; err_flag = 1'b0;
    n_fail = 0; n_rows = 0; n_solutions = 0; n_systems = 0;
    for (int i = 0; i < NRows; i++) begin
      ratio_mem[i] = 0; prhs_mem[i] = 0;
    end
    dir_rows[0] = mk_chk(mk_row(0, 32'sh10000, 0, 32'sh30000, 1), 32'sh30000, 0);
    dir_rows[1] = mk_chk(mk_row(0, 0, 0, 32'sh10000, 1), 32'sh7fffffff, 1);
    dir_rows[2] = mk_chk(mk_row(0, 0, 0, -32'sh10000, 1), 32'sh80000000, 1);
    dir_rows[3] = mk_chk(mk_row(32'sh7fffffff, 32'sh1, 32'sh7fffffff, 32'sh7fffffff, 1),
                         32'sh7fffffff, 1);
    dir_rows[4] = mk_chk(mk_row(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                32'sh80000000, 1), 32'sh10000, 0);
    dir_rows[5] = mk_row(0, 32'sh20000, 32'sh10000, 32'sh40000, 0);
    dir_rows[6] = mk_row(32'sh10000, 32'sh20000, 32'sh10000, 32'sh40000, 0);
    dir_rows[7] = mk_row(32'sh10000, 32'sh20000, 0, 32'sh30000, 1);
    dir_rows[8] = mk_row(0, 32'sh10000, 32'sh10000, 32'sh10000, 0);
    dir_rows[9] = mk_row(32'sh10000, 32'sh10000, 0, 32'sh10000, 1);
    dir_rows[10] = mk_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    dir_rows[11] = mk_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1);
    dir_rows[12] = mk_row(32'shffffffff, 32'sh7fffffff, 32'shffffffff, 32'shffffffff, 0);
    dir_rows[13] = mk_row(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 0);
    dir_rows[14] = mk_row(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 1);
    dir_rows[15] = mk_chk(mk_row(32'sh7fffffff, 32'sh10000, 0, 0, 1), 0, 0);
    dir_rows[16] = mk_row(0, 32'sh40000, 32'sh8000, -32'sh10000, 0);
    dir_rows[17] = mk_row(-32'sh8000, 32'sh40000, 32'sh8000, 32'sh18000, 0);
    dir_rows[18] = mk_row(-32'sh8000, 32'sh40000, 32'sh8000, -32'sh20000, 0);
    dir_rows[19] = mk_row(-32'sh8000, 32'sh40000, 32'sh8000, 32'sh1, 1);

    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_row(dir_rows[i]);

    // full-length system hits the row limit without a last-row mark
    for (int i = 0; i < NRows; i++)
      send_row(mk_row(rand_coef(), 32'sh40000 + $urandom_range(0, 32'hffff), rand_coef(),
                      rand_coef(), 1'b0));

    while (n_rows < 460) begin
      if ($urandom_range(0, 19) == 0) len = $urandom_range(20, NRows);
      else len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        row_req_t r;
        r = mk_row(rand_coef(), rand_coef(), rand_coef(), rand_coef(), i == len - 1);
        if ($urandom_range(0, 2) != 0)
          r.diag_c = 32'sh30000 + $signed($urandom_range(0, 32'h3ffff));
        send_row(r);
      end
    end
    start <= 1'b0;

    while (pending_solutions.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d rows in %0d systems sent, %0d solutions checked",
             n_rows, n_systems, n_solutions);
    if (n_fail == 0 && pending_solutions.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #(8 * 400_000);
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
design/tss_pkg.sv
design/tss_divider.sv
design/tss_mul.sv
design/tridiagonal_system_solver_unit.sv
dv/testbench.sv
